// ===== rtl/core/sbht_pkg.sv =====
// ----------------------------------------------------------------------------
// sbht_pkg
// Shared constants for the segment versus box hit time pipeline.
// ----------------------------------------------------------------------------
package sbht_pkg;

  localparam int COORD_BITS_DEF     = 24;
  localparam int TIME_FRAC_BITS_DEF = 16;

endpackage

// ===== rtl/core/sbht_slab.sv =====
// ----------------------------------------------------------------------------
// sbht_slab
// One axis of the slab test. It forms the entry and exit time numerators over
// a common denominator 2*|delta|, and checks the parallel case.
// ----------------------------------------------------------------------------
module sbht_slab
  import sbht_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0] s,
  input  logic signed [COORD_BITS-1:0] e,
  input  logic signed [COORD_BITS-1:0] c,
  input  logic        [COORD_BITS-2:0] w,
  output logic signed [COORD_BITS+2:0] near_num,
  output logic signed [COORD_BITS+2:0] far_num,
  output logic        [COORD_BITS+1:0] den,
  output logic                         par,
  output logic                         par_ok
);

  localparam int NW = COORD_BITS + 3;

  logic signed [NW-1:0]         s2;
  logic signed [NW-1:0]         c2;
  logic signed [NW-1:0]         wx;
  logic signed [NW-1:0]         lo2;
  logic signed [NW-1:0]         hi2;
  logic signed [COORD_BITS:0]   d;
  logic        [COORD_BITS:0]   dmag;

  assign s2  = {{2{s[COORD_BITS-1]}}, s, 1'b0};
  assign c2  = {{2{c[COORD_BITS-1]}}, c, 1'b0};
  assign wx  = {4'b0000, w};
  assign lo2 = c2 - wx;
  assign hi2 = c2 + wx;
  assign d   = {e[COORD_BITS-1], e} - {s[COORD_BITS-1], s};
  assign dmag = d[COORD_BITS] ? (~d + 1'b1) : d;

  assign den      = {dmag, 1'b0};
  assign par      = (d == '0);
  assign par_ok   = (s2 > lo2) && (s2 < hi2);
  assign near_num = d[COORD_BITS] ? (s2 - hi2) : (lo2 - s2);
  assign far_num  = d[COORD_BITS] ? (s2 - lo2) : (hi2 - s2);

endmodule

// ===== rtl/core/sbht_cross.sv =====
// ----------------------------------------------------------------------------
// sbht_cross
// Cross-multiplication stage: forms the four products that order the
// entry and exit times of the two axes.
// ----------------------------------------------------------------------------
module sbht_cross
  import sbht_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS+2:0] nx,
  input  logic signed [COORD_BITS+2:0] fx,
  input  logic        [COORD_BITS+1:0] dx,
  input  logic                         px,
  input  logic                         pokx,
  input  logic signed [COORD_BITS+2:0] ny,
  input  logic signed [COORD_BITS+2:0] fy,
  input  logic        [COORD_BITS+1:0] dy,
  input  logic                         py,
  input  logic                         poky,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [2*COORD_BITS+5:0] prod_a,
  output logic signed [2*COORD_BITS+5:0] prod_b,
  output logic signed [2*COORD_BITS+5:0] prod_c,
  output logic signed [2*COORD_BITS+5:0] prod_d,
  output logic signed [COORD_BITS+2:0] nx_q,
  output logic signed [COORD_BITS+2:0] fx_q,
  output logic        [COORD_BITS+1:0] dx_q,
  output logic                         px_q,
  output logic signed [COORD_BITS+2:0] ny_q,
  output logic signed [COORD_BITS+2:0] fy_q,
  output logic        [COORD_BITS+1:0] dy_q,
  output logic                         py_q,
  output logic                         ok_q
);

  logic signed [COORD_BITS+2:0] sdx;
  logic signed [COORD_BITS+2:0] sdy;

  assign sdx      = {1'b0, dx};
  assign sdy      = {1'b0, dy};
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      prod_a <= nx * sdy;
      prod_b <= fy * sdx;
      prod_c <= ny * sdx;
      prod_d <= fx * sdy;
      nx_q   <= nx;
      fx_q   <= fx;
      dx_q   <= dx;
      px_q   <= px;
      ny_q   <= ny;
      fy_q   <= fy;
      dy_q   <= dy;
      py_q   <= py;
      // A parallel axis misses unless its start is strictly inside the slab.
      ok_q   <= (!px || pokx) && (!py || poky);
    end
  end

endmodule

// ===== rtl/core/sbht_select.sv =====
// ----------------------------------------------------------------------------
// sbht_select
// Decision stage: rejects disjoint intervals, picks the later entry and the
// earlier exit, and checks both against the segment's time range.
// ----------------------------------------------------------------------------
module sbht_select
  import sbht_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [2*COORD_BITS+5:0] prod_a,
  input  logic signed [2*COORD_BITS+5:0] prod_b,
  input  logic signed [2*COORD_BITS+5:0] prod_c,
  input  logic signed [2*COORD_BITS+5:0] prod_d,
  input  logic signed [COORD_BITS+2:0]   nx,
  input  logic signed [COORD_BITS+2:0]   fx,
  input  logic        [COORD_BITS+1:0]   dx,
  input  logic                           px,
  input  logic signed [COORD_BITS+2:0]   ny,
  input  logic signed [COORD_BITS+2:0]   fy,
  input  logic        [COORD_BITS+1:0]   dy,
  input  logic                           py,
  input  logic                           ok,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           hit,
  output logic                           do_div,
  output logic        [COORD_BITS+1:0]   num_q,
  output logic        [COORD_BITS+1:0]   den_q
);

  logic                         both_fin;
  logic                         rej;
  logic                         near_x;
  logic                         far_x;
  logic                         near_fin;
  logic                         far_fin;
  logic signed [COORD_BITS+2:0] nnum;
  logic        [COORD_BITS+1:0] nden;
  logic signed [COORD_BITS+2:0] fnum;
  logic signed [COORD_BITS+2:0] nden_s;
  logic                         hit_c;

  assign both_fin = !px && !py;
  assign rej      = both_fin && ((prod_a > prod_b) || (prod_c > prod_d));
  // With one axis parallel its entry is minus infinity and its exit plus
  // infinity, so the other axis decides.
  assign near_x   = py || (both_fin && (prod_a > prod_c));
  assign far_x    = py || (both_fin && (prod_d < prod_b));
  assign near_fin = !(px && py);
  assign far_fin  = !(px && py);
  assign nnum     = near_x ? nx : ny;
  assign nden     = near_x ? dx : dy;
  assign fnum     = far_x ? fx : fy;
  assign nden_s   = {1'b0, nden};
  assign hit_c    = ok && !rej && !(near_fin && (nnum >= nden_s))
                    && !(far_fin && (fnum <= 0));
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      hit    <= hit_c;
      do_div <= hit_c && near_fin && (nnum > 0);
      num_q  <= nnum[COORD_BITS+1:0];
      den_q  <= nden;
    end
  end

endmodule

// ===== rtl/core/sbht_div.sv =====
// ----------------------------------------------------------------------------
// sbht_div
// Pipelined restoring divider, one quotient bit per stage, followed by the
// rounding and output register.
// ----------------------------------------------------------------------------
module sbht_div
  import sbht_pkg::*;
#(
  parameter int COORD_BITS     = COORD_BITS_DEF,
  parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        hit,
  input  logic                        do_div,
  input  logic [COORD_BITS+1:0]       num,
  input  logic [COORD_BITS+1:0]       den,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_hit,
  output logic [TIME_FRAC_BITS:0]     out_time
);

  localparam int N  = TIME_FRAC_BITS + 1;
  localparam int DW = COORD_BITS + 2;

  logic            v    [0:N];
  logic            rdy  [0:N];
  logic            h    [0:N];
  logic            dq   [0:N];
  logic [DW-1:0]   r    [0:N];
  logic [DW-1:0]   d    [0:N];
  logic [N-1:0]    q    [0:N];
  logic [N:0]      q_inc;

  assign v[0]     = in_valid;
  assign h[0]     = hit;
  assign dq[0]    = do_div;
  assign r[0]     = num;
  assign d[0]     = den;
  assign q[0]     = '0;
  assign in_ready = rdy[0];
  assign rdy[N]   = !out_valid || out_ready;

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [DW:0] r2;
    logic        ge;

    assign r2     = {r[k], 1'b0};
    assign ge     = (r2 >= {1'b0, d[k]});
    assign rdy[k] = !v[k+1] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (rdy[k]) begin
        v[k+1] <= v[k];
      end
      if (rdy[k] && v[k]) begin
        h[k+1]  <= h[k];
        dq[k+1] <= dq[k];
        d[k+1]  <= d[k];
        r[k+1]  <= ge ? DW'(r2 - {1'b0, d[k]}) : r2[DW-1:0];
        q[k+1]  <= {q[k][N-2:0], ge};
      end
    end
  end

  // Round half up; a quotient just below one rounds to one exactly.
  assign q_inc = {1'b0, q[N]} + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy[N]) begin
      out_valid <= v[N];
    end
    if (rdy[N] && v[N]) begin
      out_hit  <= h[N];
      out_time <= dq[N] ? q_inc[N:1] : '0;
    end
  end

endmodule

// ===== rtl/core/segment_box_hit_time_unit.sv =====
// ----------------------------------------------------------------------------
// segment_box_hit_time_unit
// Segment versus axis-aligned box slab test with exact entry time.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one query per beat: s_tdata holds the segment
//   start and end points, the box center and the box size. The master
//   stream returns one result per query, in order: a hit flag and the
//   entry time in unsigned Q1.TIME_FRAC_BITS (one is 2^TIME_FRAC_BITS).
//   A miss returns zero for both.
//   Throughput is one beat per cycle while the receiver takes results.
//   The registered stages are, in order: slab edges, cross products,
//   selection, one divider stage per quotient bit and the output
//   register. The quotient bits set the depth.
//   Every stage holds its own valid bit and is ready while empty or
//   while the stage after it moves, so when the receiver stalls the
//   pipeline fills up and s_tready drops only once every stage is full.
//   A synchronous reset empties the pipeline; nothing else is cleared.
// ----------------------------------------------------------------------------
module segment_box_hit_time_unit
  import sbht_pkg::*;
#(
  parameter int COORD_BITS     = COORD_BITS_DEF,
  parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  // start_x, start_y, end_x, end_y, box_center_x, box_center_y,
  // box_width, box_height, then zero fill
  input  logic [8*COORD_BITS-1:0] s_tdata,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // hit, hit_time, then zero fill
  output logic [((TIME_FRAC_BITS+9)/8)*8-1:0] m_tdata
);

  localparam int W  = COORD_BITS;
  localparam int OW = ((TIME_FRAC_BITS + 9) / 8) * 8;

  logic signed [W-1:0] in_sx, in_sy, in_ex, in_ey, in_cx, in_cy;
  logic        [W-2:0] in_w, in_h;

  assign in_sx = s_tdata[W-1:0];
  assign in_sy = s_tdata[2*W-1:W];
  assign in_ex = s_tdata[3*W-1:2*W];
  assign in_ey = s_tdata[4*W-1:3*W];
  assign in_cx = s_tdata[5*W-1:4*W];
  assign in_cy = s_tdata[6*W-1:5*W];
  assign in_w  = s_tdata[7*W-2:6*W];
  assign in_h  = s_tdata[8*W-3:7*W-1];

  logic signed [W+2:0] cnx, cfx, cny, cfy;
  logic        [W+1:0] cdx, cdy;
  logic                cpx, cpy, cokx, coky;

  sbht_slab #(.COORD_BITS(W)) u_slab_x (
    .s(in_sx), .e(in_ex), .c(in_cx), .w(in_w),
    .near_num(cnx), .far_num(cfx), .den(cdx), .par(cpx), .par_ok(cokx)
  );

  sbht_slab #(.COORD_BITS(W)) u_slab_y (
    .s(in_sy), .e(in_ey), .c(in_cy), .w(in_h),
    .near_num(cny), .far_num(cfy), .den(cdy), .par(cpy), .par_ok(coky)
  );

  // Stage one: slab times.
  logic                v1;
  logic                rdy1;
  logic                rdy2;
  logic signed [W+2:0] nx1, fx1, ny1, fy1;
  logic        [W+1:0] dx1, dy1;
  logic                px1, py1, okx1, oky1;

  assign s_tready = !v1 || rdy2;
  assign rdy1     = s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= s_tvalid;
    end
    if (rdy1 && s_tvalid) begin
      nx1  <= cnx;
      fx1  <= cfx;
      dx1  <= cdx;
      px1  <= cpx;
      okx1 <= cokx;
      ny1  <= cny;
      fy1  <= cfy;
      dy1  <= cdy;
      py1  <= cpy;
      oky1 <= coky;
    end
  end

  logic                  v2;
  logic                  rdy3;
  logic signed [2*W+5:0] pa, pb, pc, pd;
  logic signed [W+2:0]   nx2, fx2, ny2, fy2;
  logic        [W+1:0]   dx2, dy2;
  logic                  px2, py2, ok2;

  sbht_cross #(.COORD_BITS(W)) u_cross (
    .clk(clk), .rst(rst),
    .in_valid(v1), .in_ready(rdy2),
    .nx(nx1), .fx(fx1), .dx(dx1), .px(px1), .pokx(okx1),
    .ny(ny1), .fy(fy1), .dy(dy1), .py(py1), .poky(oky1),
    .out_valid(v2), .out_ready(rdy3),
    .prod_a(pa), .prod_b(pb), .prod_c(pc), .prod_d(pd),
    .nx_q(nx2), .fx_q(fx2), .dx_q(dx2), .px_q(px2),
    .ny_q(ny2), .fy_q(fy2), .dy_q(dy2), .py_q(py2), .ok_q(ok2)
  );

  logic         v3;
  logic         rdy4;
  logic         hit3;
  logic         dq3;
  logic [W+1:0] num3;
  logic [W+1:0] den3;

  sbht_select #(.COORD_BITS(W)) u_select (
    .clk(clk), .rst(rst),
    .in_valid(v2), .in_ready(rdy3),
    .prod_a(pa), .prod_b(pb), .prod_c(pc), .prod_d(pd),
    .nx(nx2), .fx(fx2), .dx(dx2), .px(px2),
    .ny(ny2), .fy(fy2), .dy(dy2), .py(py2), .ok(ok2),
    .out_valid(v3), .out_ready(rdy4),
    .hit(hit3), .do_div(dq3), .num_q(num3), .den_q(den3)
  );

  logic                      o_hit;
  logic [TIME_FRAC_BITS:0]   o_time;

  sbht_div #(.COORD_BITS(W), .TIME_FRAC_BITS(TIME_FRAC_BITS)) u_div (
    .clk(clk), .rst(rst),
    .in_valid(v3), .in_ready(rdy4),
    .hit(hit3), .do_div(dq3), .num(num3), .den(den3),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_hit(o_hit), .out_time(o_time)
  );

  assign m_tdata = OW'({o_time, o_hit});

endmodule

// ===== rtl/core/sbht_check.sv =====
// ----------------------------------------------------------------------------
// sbht_check
// Port-level checks for the hit time unit, bound to the top level.
// ----------------------------------------------------------------------------
module sbht_check
  import sbht_pkg::*;
#(
  parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    s_tready,
  input logic                    m_tvalid,
  input logic                    m_tready,
  input logic [((TIME_FRAC_BITS+9)/8)*8-1:0] m_tdata
);

  localparam logic [TIME_FRAC_BITS:0] ONE = (TIME_FRAC_BITS + 1)'(1) << TIME_FRAC_BITS;

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[TIME_FRAC_BITS+1:1] == '0))
    else $error("miss with nonzero hit time");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[TIME_FRAC_BITS+1:1] <= ONE))
    else $error("hit time above one");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled output beat changed");

  // With the output stage empty every stage is free to move.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while the output stage is empty");

endmodule

bind segment_box_hit_time_unit sbht_check #(
  .TIME_FRAC_BITS(TIME_FRAC_BITS)
) u_sbht_check (.*);

// ===== bench/tb_segment_box_hit_time_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_box_hit_time_unit
// Stream bench for the segment versus box slab test. A short table of
// directed queries is followed by random queries, mostly segments aimed
// near a small box. Every result beat is checked in order against a typed
// answer or an exact rational model of the slab test.
// ----------------------------------------------------------------------------
module tb_segment_box_hit_time_unit;
  import sbht_pkg::*;

  localparam int CB       = COORD_BITS_DEF;
  localparam int TFB      = TIME_FRAC_BITS_DEF;
  localparam int OUT_W    = ((TFB + 9) / 8) * 8;
  localparam int N_RANDOM = 1130;
  localparam int WD_LIMIT = 5000;
  localparam int HOLD_LEN = 300;

  typedef struct {
    logic signed [CB-1:0] sx, sy, ex, ey, cx, cy;
    logic [CB-2:0]        w, h;
  } query_t;

  typedef struct {
    logic           hit;
    logic [TFB:0]   hit_time;
  } answer_t;

  typedef struct {
    query_t  q;
    bit      typed;
    answer_t a;
  } row_t;

  // kind: -1 minus infinity, 0 finite num/den with den > 0, +1 plus infinity
  typedef struct {
    int     kind;
    longint num;
    longint den;
  } slab_t;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [8*CB-1:0]   s_tdata;
  logic              m_tvalid;
  logic              m_tready;
  logic [OUT_W-1:0]  m_tdata;

  row_t    queries[$];
  answer_t pending_answers[$];
  int      mismatches;
  int      sent_count;
  bit      sending_done;

  segment_box_hit_time_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int cmp_slab(slab_t a, slab_t b);
    int sa, sb;
    longint l, r;
    if (a.kind != b.kind) return (a.kind < b.kind) ? -1 : 1;
    if (a.kind != 0) return 0;
    sa = (a.num > 0) - (a.num < 0);
    sb = (b.num > 0) - (b.num < 0);
    if (sa != sb) return (sa < sb) ? -1 : 1;
    l = a.num * b.den;
    r = b.num * a.den;
    if (l == r) return 0;
    return (l < r) ? -1 : 1;
  endfunction

  function automatic bit slab_span(longint s, longint e, longint c, longint w,
                                   output slab_t enter_t, output slab_t leave_t);
    longint lo2, hi2, s2, d;
    lo2 = 2 * c - w;
    hi2 = 2 * c + w;
    s2  = 2 * s;
    d   = e - s;
    enter_t = '{kind: -1, num: 0, den: 1};
    leave_t = '{kind: 1, num: 0, den: 1};
    if (d == 0) return (s2 > lo2) && (s2 < hi2);
    enter_t.kind = 0;
    leave_t.kind = 0;
    enter_t.den = 2 * ((d < 0) ? -d : d);
    leave_t.den = enter_t.den;
    if (d > 0) begin
      enter_t.num = lo2 - s2;
      leave_t.num = hi2 - s2;
    end else begin
      enter_t.num = s2 - hi2;
      leave_t.num = s2 - lo2;
    end
    return 1'b1;
  endfunction

  function automatic answer_t predict_hit(query_t q);
    slab_t nx, fx, ny, fy, t_in, t_out;
    bit ok_x, ok_y, ok;
    longint rem, quo;
    answer_t a;
    ok_x = slab_span(q.sx, q.ex, q.cx, longint'(q.w), nx, fx);
    ok_y = slab_span(q.sy, q.ey, q.cy, longint'(q.h), ny, fy);
    ok = ok_x && ok_y;
    a.hit = 1'b0;
    a.hit_time = '0;
    if (ok && (cmp_slab(nx, fy) > 0 || cmp_slab(ny, fx) > 0)) ok = 1'b0;
    if (!ok) return a;
    t_in  = (cmp_slab(nx, ny) > 0) ? nx : ny;
    t_out = (cmp_slab(fx, fy) < 0) ? fx : fy;
    if (t_in.kind == 1 || (t_in.kind == 0 && t_in.num >= t_in.den)) return a;
    if (t_out.kind == -1 || (t_out.kind == 0 && t_out.num <= 0)) return a;
    a.hit = 1'b1;
    if (t_in.kind == 0 && t_in.num > 0) begin
      // One extra quotient bit, then round half up.
      rem = t_in.num;
      quo = 0;
      for (int i = 0; i <= TFB; i++) begin
        rem = rem << 1;
        quo = quo << 1;
        if (rem >= t_in.den) begin
          rem = rem - t_in.den;
          quo = quo | 1;
        end
      end
      a.hit_time = (TFB + 1)'((quo + 1) >> 1);
    end
    return a;
  endfunction

  function automatic query_t make_query(longint sx, longint sy, longint ex, longint ey,
                                        longint cx, longint cy, longint w, longint h);
    query_t q;
    q.sx = CB'(sx); q.sy = CB'(sy); q.ex = CB'(ex); q.ey = CB'(ey);
    q.cx = CB'(cx); q.cy = CB'(cy); q.w = (CB - 1)'(w); q.h = (CB - 1)'(h);
    return q;
  endfunction

  function automatic longint near_coord(longint base, int spread);
    return base + $signed($urandom_range(2 * spread)) - spread;
  endfunction

  task automatic add_row(query_t q, bit typed, logic hit, logic [TFB:0] t);
    row_t r;
    r.q = q;
    r.typed = typed;
    r.a.hit = hit;
    r.a.hit_time = t;
    queries.push_back(r);
  endtask

  task automatic build_stimulus();
    query_t q;
    longint cx, cy, w, h, sx, sy;
    int mode;
    localparam longint MAXC = 8388607;
    localparam longint MINC = -8388608;
    localparam longint MAXS = 8388607;
    // Directed rows; typed answers only where obvious.
    add_row(make_query(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, 1'b0, '0);
    add_row(make_query(0, 0, 0, 0, 0, 0, 256, 256), 1'b1, 1'b1, '0);
    add_row(make_query(-256, 0, 256, 0, 0, 0, 0, 512), 1'b1, 1'b1, 17'd32768);
    add_row(make_query(1024, 0, 2048, 0, 0, 0, 512, 512), 1'b1, 1'b0, '0);
    add_row(make_query(128, 0, 128, 0, 0, 0, 256, 256), 1'b1, 1'b0, '0);
    add_row(make_query(-1024, 0, 1024, 0, 0, 0, 512, 512), 1'b0, 1'b0, '0);
    add_row(make_query(1024, 100, -1024, -100, 0, 0, 512, 512), 1'b0, 1'b0, '0);
    add_row(make_query(-1024, -1024, 1024, 1024, 0, 0, 512, 512), 1'b0, 1'b0, '0);
    add_row(make_query(-512, 0, 512, 256, 0, 512, 1024, 512), 1'b0, 1'b0, '0);
    add_row(make_query(-2048, 0, -256, 0, 0, 0, 512, 512), 1'b0, 1'b0, '0);
    add_row(make_query(-2048, 0, -256, 0, 0, 0, 511, 512), 1'b0, 1'b0, '0);
    add_row(make_query(-300, -1000, -300, 1000, 0, 0, 600, 600), 1'b0, 1'b0, '0);
    add_row(make_query(-1000, -1000, 0, 1000, 0, 0, 300, 300), 1'b0, 1'b0, '0);
    add_row(make_query(0, -1000, 1000, 1000, 0, 0, 300, 300), 1'b0, 1'b0, '0);
    add_row(make_query(MINC, MINC, MAXC, MAXC, 0, 0, MAXS, MAXS), 1'b0, 1'b0, '0);
    add_row(make_query(MAXC, MAXC, MINC, MINC, MAXC, MINC, MAXS, MAXS), 1'b0, 1'b0, '0);
    add_row(make_query(MINC, MAXC, MAXC, MINC, MINC, MAXC, MAXS, 0), 1'b0, 1'b0, '0);
    add_row(make_query(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXS, MAXS), 1'b0, 1'b0, '0);
    add_row(make_query(MINC, MINC, MINC, MINC, MINC, MINC, MAXS, MAXS), 1'b0, 1'b0, '0);
    add_row(make_query(MINC, 0, MAXC, 1, 0, 0, 1, MAXS), 1'b0, 1'b0, '0);
    add_row(make_query(0, 0, 1, 0, 0, 0, MAXS, MAXS), 1'b0, 1'b0, '0);
    add_row(make_query(-1, 0, 1, 0, 0, 0, 1, 4), 1'b0, 1'b0, '0);
    for (int i = 0; i < N_RANDOM; i++) begin
      mode = $urandom_range(9);
      cx = near_coord(0, 4000);
      cy = near_coord(0, 4000);
      w  = $urandom_range(3000);
      h  = $urandom_range(3000);
      if (mode <= 1) begin
        // Full-range noise.
        q = make_query($signed($urandom), $signed($urandom), $signed($urandom),
                       $signed($urandom), $signed($urandom), $signed($urandom),
                       $urandom, $urandom);
      end else if (mode == 2) begin
        // Axis-parallel, start on or near a slab edge for an even width, else near the center.
        sx = cx + ((w % 2 == 0) ? w / 2 : 0) + $signed($urandom_range(2)) - 1;
        sy = near_coord(cy, 2000);
        if ($urandom_range(1)) q = make_query(sx, sy, sx, near_coord(cy, 6000), cx, cy, w, h);
        else q = make_query(sy, sx, near_coord(cy, 6000), sx, cy, cx, h, w);
      end else if (mode == 3) begin
        // Degenerate point.
        sx = near_coord(cx, 2000);
        sy = near_coord(cy, 2000);
        q = make_query(sx, sy, sx, sy, cx, cy, w, h);
      end else begin
        q = make_query(near_coord(cx, 6000), near_coord(cy, 6000),
                       near_coord(cx, 6000), near_coord(cy, 6000), cx, cy, w, h);
      end
      add_row(q, 1'b0, 1'b0, '0);
    end
  endtask

  initial begin
    row_t r;
    answer_t a;
    bit paused;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    sent_count = 0;
    sending_done = 1'b0;
    paused = 1'b0;
    build_stimulus();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (queries.size() > 0) begin
      @(posedge clk);
      if (s_tvalid && s_tready) begin
        r = queries.pop_front();
        a = r.typed ? r.a : predict_hit(r.q);
        pending_answers.push_back(a);
        sent_count++;
        if (queries.size() == 0) break;
      end
      if (s_tvalid && !s_tready) continue;
      if (!paused && sent_count >= 600) begin
        // Pause until the pipeline has drained completely.
        paused = 1'b1;
        s_tvalid <= 1'b0;
        while (pending_answers.size() > 0) @(posedge clk);
      end
      if ((sent_count < 700 || sent_count > 950) && $urandom_range(99) < 23) begin
        s_tvalid <= 1'b0;
      end else begin
        r = queries[0];
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, r.q.h, r.q.w, r.q.cy, r.q.cx, r.q.ey, r.q.ex, r.q.sy, r.q.sx};
      end
    end
    s_tvalid <= 1'b0;
    sending_done = 1'b1;
  end

  initial begin
    answer_t want;
    logic got_hit;
    logic [TFB:0] got_time;
    bit held;
    m_tready = 1'b0;
    mismatches = 0;
    held = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        got_hit  = m_tdata[0];
        got_time = m_tdata[TFB+1:1];
        if (pending_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: hit=%0d time=%0d", got_hit, got_time);
        end else begin
          want = pending_answers.pop_front();
          if (got_hit !== want.hit || got_time !== want.hit_time) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected hit=%0d time=%0d, got hit=%0d time=%0d",
                       want.hit, want.hit_time, got_hit, got_time);
          end
        end
      end
      if (!held && sent_count >= 300) begin
        // Long back-pressure so the pipeline fills and stalls its input.
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        continue;
      end
      if (sent_count >= 700 && sent_count <= 950) m_tready <= 1'b1;
      else m_tready <= ($urandom_range(99) >= 23);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WD_LIMIT) begin
        $display("segment_box_hit_time_unit verification failed");
        $finish;
      end
    end
  end

  initial begin
    wait (sending_done);
    while (pending_answers.size() > 0) @(posedge clk);
    repeat (TFB + 20) @(posedge clk);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("segment_box_hit_time_unit verification clean");
    end else begin
      $display("segment_box_hit_time_unit verification failed");
    end
    $finish;
  end

endmodule
